// ===== src/hrpe_pkg.sv =====
// ----------------------------------------------------------------------------
// hrpe_pkg
// Shared types, constants and helpers for the request path extractor.
// ----------------------------------------------------------------------------
package hrpe_pkg;

    // limits of the decoded path and of the request line
    localparam int MAX_PATH   = 4096;
    localparam int MAX_LINE   = 8192;
    localparam int PATH_W     = $clog2(MAX_PATH);
    localparam int LINE_W     = $clog2(MAX_LINE);

    // command queue between parser and decoder
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUERY   = 8'h3f;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_DOT     = 8'h2e;

    // what the decoder is asked to do with one beat
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_CHAR = 2'd1,
        CMD_CUT  = 2'd2,
        CMD_DOT  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       path_end;
        logic       status;
        logic       clear;
    } cmd_t;

    // whitespace: space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // hex digit value, bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== src/hrpe_front.sv =====
// ----------------------------------------------------------------------------
// hrpe_front
// Request line parser: tracks tokens and turns each byte into a decoder command.
// ----------------------------------------------------------------------------
module hrpe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output hrpe_pkg::cmd_t    cmd,
    output logic              cmd_push
);

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_METHOD = 5'b00010,
        PH_GAP    = 5'b00100,
        PH_URI    = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    localparam logic [hrpe_pkg::LINE_W:0] LINE_LIMIT =
        (hrpe_pkg::LINE_W + 1)'(hrpe_pkg::MAX_LINE - 1);

    phase_t                      phase_reg, phase_next;
    logic                        slash_reg, slash_next;
    logic                        after_reg, after_next;
    logic [hrpe_pkg::LINE_W-1:0] line_cnt_reg, line_cnt_next;
    logic [hrpe_pkg::LINE_W:0]   line_inc;
    logic                        term, ws, line_end;

    // token tracking and command build
    always_comb
    begin
        phase_next    = phase_reg;
        slash_next    = slash_reg;
        after_next    = after_reg;
        line_cnt_next = line_cnt_reg;
        cmd.kind      = hrpe_pkg::CMD_NONE;
        cmd.data      = in_byte;
        cmd.path_end  = 1'b0;
        cmd.status    = 1'b0;
        cmd.clear     = in_last;
        term          = (in_byte == hrpe_pkg::CH_NUL);
        ws            = hrpe_pkg::is_blank(in_byte);
        line_inc      = {1'b0, line_cnt_reg} + 1'b1;
        line_end      = term || (in_byte == hrpe_pkg::CH_LF) || in_last ||
                        (line_inc >= LINE_LIMIT);
        if (phase_reg != PH_DONE)
        begin
            line_cnt_next = line_inc[hrpe_pkg::LINE_W-1:0];
            if (!term)
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        if (!ws)
                            phase_next = PH_METHOD;
                    end
                    PH_METHOD:
                    begin
                        if (ws)
                            phase_next = PH_GAP;
                    end
                    PH_GAP:
                    begin
                        if (!ws)
                        begin
                            phase_next = PH_URI;
                            if (in_byte == hrpe_pkg::CH_SLASH)
                                slash_next = 1'b1;
                            else
                                cmd.kind = hrpe_pkg::CMD_CHAR;
                        end
                    end
                    PH_URI:
                    begin
                        if (!ws)
                        begin
                            if (slash_reg)
                            begin
                                after_next = 1'b1;
                                cmd.kind   = (in_byte == hrpe_pkg::CH_QUERY) ?
                                             hrpe_pkg::CMD_CUT : hrpe_pkg::CMD_CHAR;
                            end
                            else
                            begin
                                cmd.kind = hrpe_pkg::CMD_CHAR;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // token or line end
            if ((phase_next == PH_URI) && (line_end || ((phase_reg == PH_URI) && ws)))
            begin
                if (slash_next && !after_next)
                begin
                    cmd.kind = hrpe_pkg::CMD_DOT;
                    cmd.data = hrpe_pkg::CH_DOT;
                end
                cmd.path_end = 1'b1;
                phase_next   = PH_DONE;
            end
            else if (line_end)
            begin
                cmd.path_end = 1'b1;
                cmd.status   = 1'b1;
                phase_next   = PH_DONE;
            end
        end
        cmd_push = (cmd.kind != hrpe_pkg::CMD_NONE) || cmd.path_end || in_last;
    end

    // parser state, cleared after the final beat of a request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            slash_reg    <= 1'b0;
            after_reg    <= 1'b0;
            line_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                phase_reg    <= PH_LEAD;
                slash_reg    <= 1'b0;
                after_reg    <= 1'b0;
                line_cnt_reg <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                slash_reg    <= slash_next;
                after_reg    <= after_next;
                line_cnt_reg <= line_cnt_next;
            end
        end
    end

endmodule

// ===== src/hrpe_fifo.sv =====
// ----------------------------------------------------------------------------
// hrpe_fifo
// Short command queue between the parser and the decoder.
// ----------------------------------------------------------------------------
module hrpe_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hrpe_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output hrpe_pkg::cmd_t head_cmd,
    output logic           head_valid
);

    localparam logic [hrpe_pkg::FIFO_PTR_W-1:0] LAST_SLOT =
        hrpe_pkg::FIFO_PTR_W'(hrpe_pkg::FIFO_DEPTH - 1);
    localparam logic [hrpe_pkg::FIFO_CNT_W-1:0] DEPTH_CNT =
        hrpe_pkg::FIFO_CNT_W'(hrpe_pkg::FIFO_DEPTH);

    hrpe_pkg::cmd_t                  slot_reg [hrpe_pkg::FIFO_DEPTH];
    logic [hrpe_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [hrpe_pkg::FIFO_CNT_W-1:0] count_reg;
    logic                            do_push, do_pop;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== src/hrpe_back.sv =====
// ----------------------------------------------------------------------------
// hrpe_back
// Percent decoder with path length limit and registered result beat.
// ----------------------------------------------------------------------------
module hrpe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  hrpe_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,   // path_byte[7:0]
    output logic [1:0]     m_axis_tuser,   // has_byte[0], status[1]
    output logic           m_axis_tlast
);

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_HEX  = 3'b100
    } esc_t;

    localparam logic [hrpe_pkg::PATH_W-1:0] PATH_LIMIT =
        hrpe_pkg::PATH_W'(hrpe_pkg::MAX_PATH - 1);

    esc_t                        esc_reg, esc_next;
    logic [7:0]                  first_reg, first_next;
    logic                        cut_reg, cut_next;
    logic [hrpe_pkg::PATH_W-1:0] out_cnt_reg, out_cnt_next;
    logic                        valid_reg;
    logic [7:0]                  data_reg;
    logic                        has_reg, end_reg, status_reg;

    logic       want, put, has;
    logic [7:0] put_data, res_data;
    logic [4:0] hi, lo;

    assign cmd_pop = cmd_valid && (!valid_reg || m_axis_tready);

    // decode one command
    always_comb
    begin
        esc_next     = esc_reg;
        first_next   = first_reg;
        cut_next     = cut_reg;
        out_cnt_next = out_cnt_reg;
        want         = 1'b0;
        put_data     = cmd.data;
        hi           = hrpe_pkg::hex_val(first_reg);
        lo           = hrpe_pkg::hex_val(cmd.data);
        case (cmd.kind)
            hrpe_pkg::CMD_CHAR:
            begin
                if (!cut_reg)
                begin
                    unique case (esc_reg)
                        ESC_IDLE:
                        begin
                            if (cmd.data == hrpe_pkg::CH_PERCENT)
                                esc_next = ESC_PCT;
                            else
                                want = 1'b1;
                        end
                        ESC_PCT:
                        begin
                            first_next = cmd.data;
                            esc_next   = ESC_HEX;
                        end
                        ESC_HEX:
                        begin
                            esc_next = ESC_IDLE;
                            if (!hi[4] || !lo[4])
                            begin
                                want     = 1'b1;
                                put_data = hrpe_pkg::CH_QUERY;
                            end
                            else if ({hi[3:0], lo[3:0]} == 8'h00)
                            begin
                                cut_next = 1'b1;
                            end
                            else
                            begin
                                want     = 1'b1;
                                put_data = {hi[3:0], lo[3:0]};
                            end
                        end
                        default:
                        begin
                            esc_next = ESC_IDLE;
                        end
                    endcase
                end
            end
            hrpe_pkg::CMD_CUT:
            begin
                cut_next = 1'b1;
            end
            hrpe_pkg::CMD_DOT:
            begin
                want = 1'b1;
            end
            default:
            begin
            end
        endcase
        // length limit on the decoded path
        put = want && (out_cnt_reg < PATH_LIMIT);
        if (put)
            out_cnt_next = out_cnt_reg + 1'b1;
        has      = put;
        res_data = put ? put_data : 8'h00;
    end

    // decoder state, cleared after the final beat of a request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg     <= ESC_IDLE;
            first_reg   <= '0;
            cut_reg     <= 1'b0;
            out_cnt_reg <= '0;
        end
        else if (cmd_pop)
        begin
            if (cmd.clear)
            begin
                esc_reg     <= ESC_IDLE;
                first_reg   <= '0;
                cut_reg     <= 1'b0;
                out_cnt_reg <= '0;
            end
            else
            begin
                esc_reg     <= esc_next;
                first_reg   <= first_next;
                cut_reg     <= cut_next;
                out_cnt_reg <= out_cnt_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_pop)
        begin
            valid_reg <= has || cmd.path_end;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            data_reg   <= res_data;
            has_reg    <= has;
            end_reg    <= cmd.path_end;
            status_reg <= cmd.path_end && cmd.status;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = {status_reg, has_reg};
    assign m_axis_tlast  = end_reg;

endmodule

// ===== src/http_request_path_extractor.sv =====
// ----------------------------------------------------------------------------
// http_request_path_extractor
// Pulls the percent-decoded URI path out of an HTTP request line.
// ----------------------------------------------------------------------------
// Takes one request byte per beat and sustains one byte per cycle while the
// queue is not full. Each input beat gives at most one result beat: a decoded
// path byte (tuser[0] set), the end of the path (tlast, with tuser[1] set
// when the line held fewer than two tokens), or both. The parser classifies
// each byte in the cycle it arrives and pushes a command into a four-entry
// queue; the decoder pops one command a cycle while the output is not stalled
// into a registered result stage, after the queue. Input tready falls only
// when the queue is full. s_axis_tlast closes a request and clears all state.
module http_request_path_extractor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // in_byte[7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // path_byte[7:0]
    output logic [1:0] m_axis_tuser,    // has_byte[0], status[1]
    output logic       m_axis_tlast
);

    hrpe_pkg::cmd_t front_cmd, head_cmd;
    logic           front_push, fifo_full, head_valid, head_pop, accept;

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // byte classification
    hrpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .cmd      (front_cmd),
        .cmd_push (front_push)
    );

    // command queue
    hrpe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && front_push),
        .push_cmd   (front_cmd),
        .full       (fifo_full),
        .pop        (head_pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    // decoding and result beat
    hrpe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (head_cmd),
        .cmd_valid     (head_valid),
        .cmd_pop       (head_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // every result beat carries a byte or closes the path
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast))
        else $error("result beat with neither byte nor path end");

    // malformed status only on the closing beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("status set without path end");

    // no byte means zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'h00))
        else $error("data set on a beat without a byte");

    // a full queue stays full while the decoder pops nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (!s_axis_tready && !head_pop) |=> !s_axis_tready)
        else $error("queue drained without a pop");
`endif

endmodule

// ===== tb/http_request_path_extractor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_request_path_extractor_tb
// Self-checking testbench for the request path extractor.
// ----------------------------------------------------------------------------
// Request bytes go in on the slave stream and decoded path beats come back on
// the master stream. Every accepted byte runs through a behavioural copy of
// the extractor kept in this file, and each result beat is compared field by
// field with the oldest predicted beat. The run covers directed corner cases,
// one request with a long uri, and random request lines mixed with noise.
// Both streams idle in random bursts.
module http_request_path_extractor_tb;

    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         LONG_URI      = 256;
    localparam logic [7:0] CH_VT         = 8'h0b;
    localparam logic [7:0] CH_FF         = 8'h0c;

    // where the line scan stands
    typedef enum logic [4:0] {
        SCAN_LEAD   = 5'b00001,
        SCAN_METHOD = 5'b00010,
        SCAN_GAP    = 5'b00100,
        SCAN_URI    = 5'b01000,
        SCAN_DONE   = 5'b10000
    } scan_t;

    // percent escape progress
    typedef enum logic [2:0] {
        ESC_IDLE    = 3'b001,
        ESC_PERCENT = 3'b010,
        ESC_HIGH    = 3'b100
    } esc_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       has_byte;
        logic       path_end;
        logic       status;
    } path_beat_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    // predicted extractor state
    scan_t                       scan_state;
    esc_t                        esc_state;
    logic [7:0]                  esc_high;
    logic                        slash_seen;
    logic                        tail_seen;
    logic                        path_stopped;
    logic [hrpe_pkg::PATH_W-1:0] path_count;
    logic [hrpe_pkg::LINE_W-1:0] line_seen;
    logic [7:0]                  step_byte;
    logic                        step_has;

    path_beat_t expected_path[$];

    bit idle_on      = 1'b1;
    int sink_hold    = 0;
    int fail_count   = 0;
    int beats_sent   = 0;
    int results_seen = 0;

    http_request_path_extractor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // in_byte[7:0]
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // path_byte[7:0]
        .m_axis_tuser  (m_axis_tuser),    // has_byte[0], status[1]
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // path prediction
    // ------------------------------------------------------------------------

    function automatic logic blank_char(input logic [7:0] c);
        return (c == hrpe_pkg::CH_SPACE) ||
               ((c >= hrpe_pkg::CH_TAB) && (c <= hrpe_pkg::CH_CR));
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if ((c >= "0") && (c <= "9"))
            return int'(c - "0");
        if ((c >= "a") && (c <= "f"))
            return int'(c - "a") + 10;
        if ((c >= "A") && (c <= "F"))
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void clear_path_model();
        scan_state   = SCAN_LEAD;
        esc_state    = ESC_IDLE;
        esc_high     = 8'h00;
        slash_seen   = 1'b0;
        tail_seen    = 1'b0;
        path_stopped = 1'b0;
        path_count   = '0;
        line_seen    = '0;
    endfunction

    // one output byte, dropped once the path buffer is full
    function automatic void path_out(input logic [7:0] v);
        if (int'(path_count) < hrpe_pkg::MAX_PATH - 1)
        begin
            step_byte = v;
            step_has  = 1'b1;
            path_count++;
        end
    endfunction

    function automatic void decode_uri_char(input logic [7:0] c);
        int         hi;
        int         lo;
        logic [7:0] v;
        // a query only cuts the path when the uri began with a slash
        if (slash_seen)
        begin
            tail_seen = 1'b1;
            if (c == hrpe_pkg::CH_QUERY)
                path_stopped = 1'b1;
        end
        if (!path_stopped)
        begin
            case (esc_state)
                ESC_IDLE:
                    if (c == hrpe_pkg::CH_PERCENT)
                        esc_state = ESC_PERCENT;
                    else
                        path_out(c);
                ESC_PERCENT:
                begin
                    esc_high  = c;
                    esc_state = ESC_HIGH;
                end
                default:
                begin
                    hi        = hex_nibble(esc_high);
                    lo        = hex_nibble(c);
                    esc_state = ESC_IDLE;
                    if ((hi < 0) || (lo < 0))
                        path_out(hrpe_pkg::CH_QUERY);
                    else
                    begin
                        v = 8'(hi * 16 + lo);
                        if (v == 8'h00)
                            path_stopped = 1'b1;
                        else
                            path_out(v);
                    end
                end
            endcase
        end
    endfunction

    function automatic void predict_beat(input logic [7:0] b, input logic lst);
        path_beat_t want;
        logic       term;
        logic       ws;
        logic       was_uri;
        logic       line_end;
        want      = '0;
        step_byte = 8'h00;
        step_has  = 1'b0;
        if (scan_state != SCAN_DONE)
        begin
            term    = (b == hrpe_pkg::CH_NUL);
            ws      = blank_char(b);
            was_uri = (scan_state == SCAN_URI);
            line_seen++;
            line_end = term || (b == hrpe_pkg::CH_LF) || lst ||
                       (int'(line_seen) >= hrpe_pkg::MAX_LINE - 1);
            if (!term)
            begin
                case (scan_state)
                    SCAN_LEAD:
                        if (!ws)
                            scan_state = SCAN_METHOD;
                    SCAN_METHOD:
                        if (ws)
                            scan_state = SCAN_GAP;
                    SCAN_GAP:
                        if (!ws)
                        begin
                            scan_state = SCAN_URI;
                            if (b == hrpe_pkg::CH_SLASH)
                                slash_seen = 1'b1;
                            else
                                decode_uri_char(b);
                        end
                    default:
                        if (!ws)
                            decode_uri_char(b);
                endcase
            end
            // uri token closes, or the line closes before any uri
            if ((scan_state == SCAN_URI) && (line_end || (was_uri && ws)))
            begin
                if (slash_seen && !tail_seen)
                    path_out(hrpe_pkg::CH_DOT);
                want.path_end = 1'b1;
                scan_state    = SCAN_DONE;
            end
            else if (line_end)
            begin
                want.path_end = 1'b1;
                want.status   = 1'b1;
                scan_state    = SCAN_DONE;
            end
        end
        if (lst)
            clear_path_model();
        if (step_has || want.path_end)
        begin
            want.path_byte = step_byte;
            want.has_byte  = step_has;
            expected_path.push_back(want);
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // sample at the falling edge, ahead of the edge that takes the beat
    always @(negedge clk)
    begin : result_check
        path_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_path.size() == 0)
            begin
                $error("result beat with nothing expected: data %0h user %0h last %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_path.pop_front();
                check_field("path_byte", want.path_byte, m_axis_tdata);
                check_field("has_byte", 8'(want.has_byte), 8'(m_axis_tuser[0]));
                check_field("path_end", 8'(want.path_end), 8'(m_axis_tlast));
                check_field("status", 8'(want.status), 8'(m_axis_tuser[1]));
            end
        end
    end

    // receiver stalls in bursts of random length
    always @(posedge clk)
    begin
        if (sink_hold != 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && ($urandom_range(0, 5) == 0))
        begin
            sink_hold     <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one request byte; returns at the edge that takes it
    task automatic send_beat(input logic [7:0] b, input logic lst);
        if (idle_on && ($urandom_range(0, 3) == 0))
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do
            @(negedge clk);
        while (!s_axis_tready);
        predict_beat(b, lst);
        beats_sent++;
        @(posedge clk);
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int k = 0; k < s.len(); k++)
            send_beat(s[k], last_at_end && (k == s.len() - 1));
    endtask

    // sender holds off until every predicted beat has come back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_path.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 4))
            0:       return hrpe_pkg::CH_SPACE;
            1:       return hrpe_pkg::CH_TAB;
            2:       return CH_VT;
            3:       return CH_FF;
            default: return hrpe_pkg::CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return 8'("0" + v);
        if (v < 16)
            return 8'("a" + v - 10);
        return 8'("A" + v - 16);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        // escapes: good pair, bad pair, decoded zero, then a cut byte
        send_text("\tG /%41%zz%00b", 1'b1);
        // lone slash gives a dot; byte after the newline is ignored
        send_text("G /\nx", 1'b1);
        // zero byte ends a line holding one token only
        send_text("G", 1'b0);
        send_beat(hrpe_pkg::CH_NUL, 1'b1);
        // no leading slash: query kept, top byte passes, short escape dropped
        send_text("G ", 1'b0);
        send_beat(8'hff, 1'b0);
        send_text("?%4", 1'b1);
        // slash then query gives an empty path
        send_text("G /?", 1'b1);
        wait_for_drain();
    endtask

    task automatic test_long_request();
        // one long uri, closed by the final beat of the request
        send_text("G /", 1'b0);
        for (int k = 0; k < LONG_URI; k++)
            send_beat(8'($urandom_range(8'h40, 8'h7e)), k == LONG_URI - 1);
        wait_for_drain();
    endtask

    task automatic test_random_requests(input int budget);
        logic [7:0] req[$];
        string      proto;
        int         sent;
        int         form;
        int         next_pause;
        proto      = " HTTP/1.1\r";
        sent       = 0;
        next_pause = budget / 3;
        while (sent < budget)
        begin
            req.delete();
            form = $urandom_range(0, 9);
            if (form == 0)
            begin
                // noise of any byte values
                repeat ($urandom_range(1, 12)) req.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(0, 2)) req.push_back(rand_blank());
                repeat ($urandom_range(1, 6)) req.push_back(8'($urandom_range(8'h21, 8'hff)));
                if (form == 1)
                begin
                    // method token only
                    if ($urandom_range(0, 1) == 1)
                        req.push_back(rand_blank());
                    req.push_back(hrpe_pkg::CH_LF);
                end
                else
                begin
                    repeat ($urandom_range(1, 2)) req.push_back(rand_blank());
                    if ($urandom_range(0, 3) != 0)
                        req.push_back(hrpe_pkg::CH_SLASH);
                    repeat ($urandom_range(0, 16))
                    begin
                        case ($urandom_range(0, 15))
                            8, 9:
                            begin
                                req.push_back(hrpe_pkg::CH_PERCENT);
                                req.push_back(rand_hex());
                                req.push_back(rand_hex());
                            end
                            10:
                            begin
                                req.push_back(hrpe_pkg::CH_PERCENT);
                                req.push_back(8'($urandom_range(8'h21, 8'hff)));
                                req.push_back(8'($urandom_range(8'h21, 8'hff)));
                            end
                            11:
                            begin
                                req.push_back(hrpe_pkg::CH_PERCENT);
                                req.push_back("0");
                                req.push_back("0");
                            end
                            12: req.push_back(hrpe_pkg::CH_QUERY);
                            13: req.push_back(8'($urandom_range(8'h80, 8'hff)));
                            14: req.push_back(rand_blank());
                            15: req.push_back(hrpe_pkg::CH_PERCENT);
                            default: req.push_back(8'($urandom_range(8'h21, 8'h7e)));
                        endcase
                    end
                    // how the line closes
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            for (int k = 0; k < proto.len(); k++)
                                req.push_back(proto[k]);
                            req.push_back(hrpe_pkg::CH_LF);
                        end
                        1:       req.push_back(hrpe_pkg::CH_LF);
                        2:       req.push_back(hrpe_pkg::CH_NUL);
                        default: ;
                    endcase
                end
                // bytes after the line
                repeat ($urandom_range(0, 3)) req.push_back(8'($urandom_range(0, 255)));
            end
            // no idling over the tail of the run
            idle_on = (sent < budget - 250);
            foreach (req[i])
                send_beat(req[i], i == req.size() - 1);
            sent += req.size();
            if ((sent >= next_pause) && (sent < budget))
            begin
                wait_for_drain();
                next_pause += budget / 3;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        clear_path_model();
        step_byte = 8'h00;
        step_has  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_request();
        test_random_requests(1400);
        wait_for_drain();

        $display("sent %0d request bytes, checked %0d path beats", beats_sent, results_seen);
        $display("covered escape and query corners, a long uri, random lines and noise");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
